[rtl/oaid_pkg.sv]
// ----------------------------------------------------------------------------
// oaid_pkg
// Shared types and codes for the ordered array with insert, delete and search.
// ----------------------------------------------------------------------------
`default_nettype none

package oaid_pkg;

   localparam int DEPTH_DEF  = 64;
   localparam int VAL_W      = 32;
   localparam int POS_W      = 6;
   localparam int CNT_W      = 7;
   localparam int OP_W       = 2;
   localparam int ST_W       = 2;
   // match bits examined per scan cycle
   localparam int SCAN_GROUP = 8;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
   localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

   // broadcast to every cell
   typedef struct packed {
      logic ins_en;
      logic del_en;
   } cell_ctl_type;

   // scan unit back to the controller
   typedef struct packed {
      logic done;
      logic hit;
   } scan_res_type;

endpackage

`default_nettype wire

[rtl/oaid_cell.sv]
// ----------------------------------------------------------------------------
// oaid_cell
// One table entry: loads the new word, takes its lower or upper neighbor on a
// shift, and compares its entry with the search word.
// ----------------------------------------------------------------------------
`default_nettype none

module oaid_cell
   import oaid_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int INDEX = 0
) (
   input  wire                                                    clock,
   input  cell_ctl_type                                           ctl,
   input  wire  [((($clog2(DEPTH+1)) > POS_W) ? $clog2(DEPTH+1) : POS_W)-1:0] pos,
   input  wire  [((($clog2(DEPTH+1)) > POS_W) ? $clog2(DEPTH+1) : POS_W)-1:0] count,
   input  wire  signed [VAL_W-1:0]                                value,
   input  wire  signed [VAL_W-1:0]                                left,
   input  wire  signed [VAL_W-1:0]                                right,
   output logic signed [VAL_W-1:0]                                entry,
   output logic                                                   match
);

   localparam int CW    = $clog2(DEPTH+1);
   localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   logic signed [VAL_W-1:0] entry_ff;
   logic signed [VAL_W-1:0] entry_in;
   logic [CMP_W:0]          idx_next;

   assign idx_next = {1'b0, IDX} + {{CMP_W{1'b0}}, 1'b1};

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en) begin
         if (IDX == pos) begin
            entry_in = value;
         end else if ((IDX > pos) && (IDX <= count)) begin
            entry_in = left;
         end
      end else if (ctl.del_en) begin
         if ((IDX >= pos) && (idx_next < {1'b0, count})) begin
            entry_in = right;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff == value) && (IDX < count);

endmodule

`default_nettype wire

[rtl/oaid_scan.sv]
// ----------------------------------------------------------------------------
// oaid_scan
// Lowest-match finder: takes the match bits of all cells and walks them a
// group at a time from position zero up to the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module oaid_scan
   import oaid_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire                                                     clock,
   input  wire                                                     start,
   input  wire  [DEPTH-1:0]                                        match,
   input  wire  [$clog2(DEPTH+1)-1:0]                              count,
   output scan_res_type                                            res,
   output logic [$clog2(((DEPTH+SCAN_GROUP-1)/SCAN_GROUP)*SCAN_GROUP
                        + SCAN_GROUP + 1)-1:0]                     idx
);

   localparam int CW = $clog2(DEPTH+1);
   localparam int NG = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
   localparam int MW = NG * SCAN_GROUP;
   localparam int BW = $clog2(MW + SCAN_GROUP + 1);
   localparam int FW = $clog2(SCAN_GROUP);

   logic [MW-1:0]         match_ff;
   logic [MW-1:0]         match_in;
   logic [BW-1:0]         base_ff;
   logic [BW-1:0]         base_in;
   logic [SCAN_GROUP-1:0] low;
   logic [FW-1:0]         first;
   logic [BW-1:0]         base_next;
   logic                  hit;
   logic                  done;

   assign low       = match_ff[SCAN_GROUP-1:0];
   assign hit       = |low;
   assign base_next = base_ff + BW'(SCAN_GROUP);
   assign done      = hit || (base_next >= BW'(count));

   // lowest set bit of the group; descending so the lowest wins
   always_comb begin
      first = '0;
      for (int b = SCAN_GROUP - 1; b >= 0; b--) begin
         if (low[b]) begin
            first = FW'(b);
         end
      end
   end

   always_comb begin
      match_in = match_ff;
      base_in  = base_ff;
      if (start) begin
         match_in = MW'(match);
         base_in  = '0;
      end else if (!done) begin
         match_in = match_ff >> SCAN_GROUP;
         base_in  = base_next;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      base_ff  <= base_in;
   end

   assign res.done = done;
   assign res.hit  = hit;
   assign idx      = base_ff + BW'(first);

endmodule

`default_nettype wire

[rtl/ordered_array_insert_delete_search_top.sv]
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search_top
// Ordered table of signed 32-bit words held in a row of cells, with append,
// insert, delete and lowest-position search.
//
// Usage:
//   One request word (opcode, position, value) on the req_ channel gives one
//   response word (status, found_position, count) on the rsp_ channel, both
//   valid/ready. Append, insert and delete finish in the accept cycle: every
//   cell loads, shifts from its neighbor or holds at once, and the response
//   is registered at accept. A search compares all cells in the accept cycle,
//   then the scan unit walks the match bits eight positions per cycle up to
//   the fill count and stops at the first group with a hit; the response is
//   registered once the scan is done and the response register is free.
//   Throughput is one word per cycle for table updates while rsp_ready stays
//   high; a search blocks requests until its result is registered.
//   A single response register decouples the channels: a new request is
//   taken in the same cycle the pending response leaves. While rsp_ready is
//   low and a response waits, req_ready stays low.
//   Reset clears the fill count and the handshake state; entries are not
//   cleared and are never read until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_insert_delete_search_top
   import oaid_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire  [OP_W-1:0]          req_opcode,
   input  wire  [POS_W-1:0]         req_position,
   input  wire  signed [VAL_W-1:0]  req_value,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [ST_W-1:0]          rsp_status,
   output logic [POS_W-1:0]         rsp_found_position,
   output logic [CNT_W-1:0]         rsp_count
);

   localparam int CW    = $clog2(DEPTH+1);
   localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
   localparam int NG    = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
   localparam int BW    = $clog2(NG * SCAN_GROUP + SCAN_GROUP + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                    state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]        rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic                    out_free;
   logic                    accept;
   logic                    full;
   logic [CMP_W-1:0]        pos_ext;
   logic [CMP_W-1:0]        cnt_ext;
   logic [CMP_W-1:0]        pos_sel;
   logic [ST_W-1:0]         upd_status;
   cell_ctl_type            ctl;
   logic                    scan_start;
   scan_res_type            scan_res;
   logic [BW-1:0]           scan_idx;

   logic signed [VAL_W-1:0] entry [DEPTH];
   logic [DEPTH-1:0]        match;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign full    = (count_ff == CW'(DEPTH));
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   // append is an insert at the fill count
   assign pos_sel = (req_opcode == OP_APPEND) ? cnt_ext : pos_ext;

   always_comb begin
      ctl.ins_en = 1'b0;
      ctl.del_en = 1'b0;
      upd_status = ST_DONE;
      case (req_opcode)
         OP_APPEND: begin
            if (full) begin
               upd_status = ST_FULL;
            end else begin
               ctl.ins_en = accept;
            end
         end
         OP_INSERT: begin
            if (pos_ext > cnt_ext) begin
               upd_status = ST_RANGE;
            end else if (full) begin
               upd_status = ST_FULL;
            end else begin
               ctl.ins_en = accept;
            end
         end
         OP_DELETE: begin
            if (pos_ext >= cnt_ext) begin
               upd_status = ST_RANGE;
            end else begin
               ctl.del_en = accept;
            end
         end
         default: begin
            upd_status = ST_DONE;
         end
      endcase
   end

   assign scan_start = accept && (req_opcode == OP_SEARCH);

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_w;
      logic signed [VAL_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = req_value;
      end else begin : g_left
         assign left_w = entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = entry[i];
      end else begin : g_right
         assign right_w = entry[i+1];
      end
      oaid_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock (clock),
         .ctl   (ctl),
         .pos   (pos_sel),
         .count (cnt_ext),
         .value (req_value),
         .left  (left_w),
         .right (right_w),
         .entry (entry[i]),
         .match (match[i])
      );
   end

   oaid_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock (clock),
      .start (scan_start),
      .match (match),
      .count (count_ff),
      .res   (scan_res),
      .idx   (scan_idx)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (ctl.ins_en) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.del_en) begin
         count_in = count_ff - CW'(1);
      end
      case (state_ff)
         S_IDLE: begin
            if (scan_start) begin
               state_in = S_SCAN;
            end else if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = upd_status;
               rsp_found_in  = '0;
               rsp_count_in  = CNT_W'(count_in);
            end
         end
         S_SCAN: begin
            if (scan_res.done && out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = scan_res.hit ? ST_DONE : ST_MISS;
               rsp_found_in  = scan_res.hit ? POS_W'(scan_idx) : '0;
               rsp_count_in  = CNT_W'(count_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_count          = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_update_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode != OP_SEARCH)) |=> rsp_valid_ff)
      else $error("update word gave no response");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> (count_ff == $past(count_ff)))
      else $error("fill count moved during search");

   a_no_shift_fail: assert property (@(posedge clock) disable iff (reset)
      (ctl.ins_en || ctl.del_en) |-> (upd_status == ST_DONE))
      else $error("table shifted on a failed update");

   a_scan_blocks: assert property (@(posedge clock) disable iff (reset)
      scan_start |=> !req_ready)
      else $error("request taken while search in flight");

endmodule

`default_nettype wire

[verif/ordered_array_insert_delete_search_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search_top_test
// Drives append/insert/delete/search words into the ordered table, keeps a
// shadow table to predict each response word, and compares every response
// field by field. Stimulus: a short directed set of corner cases, then random
// fill/drain/mixed/noise episodes under changing backpressure.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_search_top_test;
   import oaid_pkg::*;

   localparam int TBL_DEPTH   = DEPTH_DEF;
   localparam int ITEM_TARGET = 1125;
   localparam int SETTLE_CYC  = 20;

   typedef struct {
      logic [OP_W-1:0]         opcode;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
      bit                      drain;   // hold off until all responses are back
   } req_word_type;

   typedef struct {
      logic [ST_W-1:0]  status;
      logic [POS_W-1:0] found_position;
      logic [CNT_W-1:0] count;
   } rsp_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OP_W-1:0]         req_opcode = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [ST_W-1:0]         rsp_status;
   logic [POS_W-1:0]        rsp_found_position;
   logic [CNT_W-1:0]        rsp_count;

   ordered_array_insert_delete_search_top #(
      .DEPTH(TBL_DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_position(rsp_found_position),
      .rsp_count         (rsp_count)
   );

   always #5 clock = ~clock;

   // shadow table
   logic [VAL_W-1:0] tbl [TBL_DEPTH];
   int               tbl_fill = 0;

   req_word_type     req_backlog [$];
   rsp_word_type     rsp_expect_q [$];
   req_word_type     cur_req;
   logic [VAL_W-1:0] val_pool [$];
   int               gen_fill = 0;
   bit               gen_drain = 0;
   int               gen_items = 0;
   int               drv_cnt = 0;
   bit               req_taken = 0;
   bit               hold_rsp = 0;
   int unsigned      mismatch_cnt = 0;
   int               snd_idle_pct;
   int               rcv_idle_pct;

   assign snd_idle_pct = (drv_cnt < 400) ? 11 : (drv_cnt < 800) ? 65 : 0;
   assign rcv_idle_pct = (drv_cnt < 400) ? 65 : (drv_cnt < 800) ? 11 : 0;

   function automatic rsp_word_type apply_table_op(req_word_type w);
      rsp_word_type r;
      int           i;
      r.status         = ST_DONE;
      r.found_position = '0;
      case (w.opcode)
         OP_APPEND: begin
            if (tbl_fill >= TBL_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               tbl[tbl_fill] = w.value;
               tbl_fill++;
            end
         end
         OP_INSERT: begin
            // range check wins over full
            if (int'(w.position) > tbl_fill) begin
               r.status = ST_RANGE;
            end else if (tbl_fill >= TBL_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (i = tbl_fill; i > int'(w.position); i--)
                  tbl[i] = tbl[i-1];
               tbl[w.position] = w.value;
               tbl_fill++;
            end
         end
         OP_DELETE: begin
            if (int'(w.position) >= tbl_fill) begin
               r.status = ST_RANGE;
            end else begin
               for (i = int'(w.position); i + 1 < tbl_fill; i++)
                  tbl[i] = tbl[i+1];
               tbl_fill--;
            end
         end
         default: begin
            r.status = ST_MISS;
            for (i = 0; i < tbl_fill; i++) begin
               if (tbl[i] == w.value) begin
                  r.status         = ST_DONE;
                  r.found_position = i[POS_W-1:0];
                  break;
               end
            end
         end
      endcase
      r.count = tbl_fill[CNT_W-1:0];
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         4, 5:    return $urandom_range(0, 7);   // duplicates on purpose
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] search_value();
      if (val_pool.size() == 0 || $urandom_range(0, 9) < 3)
         return pick_value();
      return val_pool[$urandom_range(0, val_pool.size() - 1)];
   endfunction

   // queue one request word and track the fill the table will have after it
   task automatic push_req(input logic [OP_W-1:0] op, input int pos,
                           input logic [VAL_W-1:0] val);
      req_word_type w;
      w.opcode   = op;
      w.position = pos[POS_W-1:0];
      w.value    = val;
      w.drain    = gen_drain;
      gen_drain  = 0;
      req_backlog.push_back(w);
      gen_items++;
      case (op)
         OP_APPEND: begin
            if (gen_fill < TBL_DEPTH) begin
               gen_fill++;
               val_pool.push_back(val);
            end
         end
         OP_INSERT: begin
            if (int'(w.position) <= gen_fill && gen_fill < TBL_DEPTH) begin
               gen_fill++;
               val_pool.push_back(val);
            end
         end
         OP_DELETE: begin
            if (int'(w.position) < gen_fill)
               gen_fill--;
         end
         default: ;
      endcase
   endtask

   // stimulus and end of run
   initial begin
      int kind;
      int n;
      int r;

      // directed corner cases, table starts empty
      push_req(OP_DELETE, 0, 32'h1);            // delete on empty
      push_req(OP_SEARCH, 0, 32'h0);            // search on empty
      push_req(OP_INSERT, 1, 32'h5);            // insert past count
      push_req(OP_INSERT, 0, 32'h8000_0000);    // insert at count acts as append
      push_req(OP_APPEND, 63, 32'h7fff_ffff);
      push_req(OP_APPEND, 0, 32'h7fff_ffff);
      push_req(OP_INSERT, 3, 32'h0);
      push_req(OP_INSERT, 1, 32'hffff_ffff);
      push_req(OP_SEARCH, 17, 32'h7fff_ffff);   // lowest of two copies
      push_req(OP_SEARCH, 0, 32'h8000_0000);
      push_req(OP_SEARCH, 0, 32'h5);            // miss
      push_req(OP_INSERT, 63, 32'h1234_5678);
      push_req(OP_DELETE, 5, 32'h0);            // delete at count
      push_req(OP_DELETE, 63, 32'h0);
      push_req(OP_DELETE, 0, 32'h0);
      push_req(OP_DELETE, 3, 32'h0);            // last entry
      push_req(OP_SEARCH, 0, 32'h0);
      push_req(OP_DELETE, 1, 32'h0);
      push_req(OP_SEARCH, 42, 32'h7fff_ffff);
      push_req(OP_DELETE, 0, 32'h0);
      push_req(OP_DELETE, 0, 32'h0);
      push_req(OP_APPEND, 63, 32'h5555_5555);
      push_req(OP_SEARCH, 63, 32'haaaa_aaaa);
      push_req(OP_DELETE, 0, 32'hffff_ffff);

      kind = 0;
      gen_drain = 1;
      while (gen_items < ITEM_TARGET) begin
         if ($urandom_range(0, 7) == 0)
            gen_drain = 1;
         case (kind)
            0: begin
               // fill to the top, then bang on the full table
               while (gen_fill < TBL_DEPTH) begin
                  r = $urandom_range(0, 9);
                  if (r < 5)
                     push_req(OP_APPEND, $urandom_range(0, 63), pick_value());
                  else if (r < 8)
                     push_req(OP_INSERT, $urandom_range(0, gen_fill), pick_value());
                  else if (r < 9)
                     push_req(OP_SEARCH, $urandom_range(0, 63), search_value());
                  else
                     push_req(OP_DELETE, $urandom_range(0, gen_fill), 32'h0);
               end
               n = $urandom_range(2, 5);
               repeat (n) begin
                  r = $urandom_range(0, 2);
                  if (r == 0)
                     push_req(OP_APPEND, $urandom_range(0, 63), pick_value());
                  else if (r == 1)
                     push_req(OP_INSERT, $urandom_range(0, 63), pick_value());
                  else
                     push_req(OP_SEARCH, $urandom_range(0, 63), search_value());
               end
            end
            1: begin
               // drain to empty
               while (gen_fill > 0) begin
                  r = $urandom_range(0, 9);
                  if (r < 7)
                     push_req(OP_DELETE, $urandom_range(0, gen_fill - 1), pick_value());
                  else if (r < 9)
                     push_req(OP_SEARCH, $urandom_range(0, 63), search_value());
                  else
                     push_req(OP_APPEND, $urandom_range(0, 63), pick_value());
               end
               push_req(OP_DELETE, $urandom_range(0, 63), pick_value());
               push_req(OP_SEARCH, $urandom_range(0, 63), search_value());
            end
            2: begin
               repeat (20) begin
                  r = $urandom_range(0, 3);
                  if (r == 0) begin
                     push_req(OP_APPEND, $urandom_range(0, 63), pick_value());
                  end else if (r == 1) begin
                     if ($urandom_range(0, 4) != 0)
                        push_req(OP_INSERT, $urandom_range(0, gen_fill), pick_value());
                     else
                        push_req(OP_INSERT, $urandom_range(0, 63), pick_value());
                  end else if (r == 2) begin
                     if (gen_fill > 0 && $urandom_range(0, 4) != 0)
                        push_req(OP_DELETE, $urandom_range(0, gen_fill - 1), pick_value());
                     else
                        push_req(OP_DELETE, $urandom_range(0, 63), pick_value());
                  end else begin
                     push_req(OP_SEARCH, $urandom_range(0, 63), search_value());
                  end
               end
            end
            default: begin
               repeat (10)
                  push_req(OP_W'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom);
            end
         endcase
         r = $urandom_range(0, 99);
         if (r < 25)
            kind = 0;
         else if (r < 45)
            kind = (gen_fill > 0) ? 1 : 0;
         else if (r < 85)
            kind = 2;
         else
            kind = 3;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid || rsp_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // long receiver hold-off so the response register fills and req_ready drops
   initial begin
      while (drv_cnt < 150)
         @(posedge clock);
      hold_rsp = 1;
      repeat (400) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // word still waiting, keep it
      end else if (req_backlog.size() == 0 ||
                   (req_backlog[0].drain && rsp_expect_q.size() != 0) ||
                   $urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
      end else begin
         cur_req = req_backlog.pop_front();
         req_valid    <= 1'b1;
         req_opcode   <= cur_req.opcode;
         req_position <= cur_req.position;
         req_value    <= cur_req.value;
         drv_cnt++;
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   // accepted request words feed the shadow table
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready)
            rsp_expect_q.push_back(apply_table_op('{req_opcode, req_position,
                                                    req_value, 1'b0}));
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expect_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("ERROR %0t: unexpected response st=%0d pos=%0d cnt=%0d",
                        $realtime, rsp_status, rsp_found_position, rsp_count);
         end else begin
            exp_w = rsp_expect_q.pop_front();
            if (rsp_status !== exp_w.status ||
                rsp_found_position !== exp_w.found_position ||
                rsp_count !== exp_w.count) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("ERROR %0t: exp st=%0d pos=%0d cnt=%0d, %s%0d pos=%0d cnt=%0d",
                           $realtime, exp_w.status, exp_w.found_position, exp_w.count,
                           "got st=", rsp_status, rsp_found_position, rsp_count);
            end
         end
      end
   end

endmodule
